FILE: rtl/int_to_decimal_ascii_macros.svh
// Assertion macros shared by the checker.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Generic clocked assertion, off while reset is asserted.
`define ITDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Payload hold under stall.
`define ITDA_ASSERT_HOLD(lbl, vld, stl, sig) \
  `ITDA_ASSERT(lbl, (vld) && (stl) |=> (vld) && $stable(sig), "stalled transfer changed")

`endif

FILE: rtl/itda_pkg.sv
package itda_pkg;

  localparam int unsigned MaxDigits = 10;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;

  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
  localparam logic [ValueW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } item_t;

endpackage

FILE: rtl/int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Input channel: value_i with valid_i/stall_o; a transfer happens on a rising
// edge with valid_i high and stall_o low. A two-entry queue holds sign and
// magnitude of numbers waiting for conversion.
// Output channel: char_code_o/last_char_o with valid_o/stall_i, one character
// per transfer, most significant digit first, '-' ahead of negative numbers,
// last_char_o set on the final character of each number.
// Timing: an entry leaves the queue once the digit unit is idle; the digit
// unit then peels one digit per cycle (one reciprocal multiply by 1/10), and
// emits one character per cycle while the receiver does not stall.
// The single digit unit converts and then emits, so it takes a new number
// from the queue only after the last character of the one before.
// A stalled receiver holds the current character; the digit unit waits and
// the queue keeps taking numbers until both entries are full.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
module int_to_decimal_ascii #(
  parameter int unsigned MAX_DIGITS = itda_pkg::MaxDigits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [itda_pkg::ValueW-1:0] value_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [itda_pkg::CharW-1:0]         char_code_o,
  output logic                               last_char_o
);

  logic            q_valid, q_pop;
  itda_pkg::item_t q_item;

  itda_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .stall_o   (stall_o),
    .value_i   (value_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  itda_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

FILE: rtl/itda_front.sv
module itda_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [itda_pkg::ValueW-1:0]  value_i,
  output logic                                q_valid_o,
  input  logic                                q_pop_i,
  output itda_pkg::item_t                     q_item_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  itda_pkg::item_t                mem_q [Depth];
  logic [PtrW-1:0]                wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                cnt_q;
  logic [itda_pkg::ValueW-1:0]    raw;
  itda_pkg::item_t                item_in;
  logic                           push, pop;

  assign raw           = value_i;
  assign item_in.neg   = raw[itda_pkg::ValueW-1];
  assign item_in.mag   = raw[itda_pkg::ValueW-1] ? (~raw + itda_pkg::ValueW'(1)) : raw;

  assign stall_o   = (cnt_q == CntW'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign push      = valid_i && !stall_o;
  assign pop       = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/itda_back.sv
module itda_back #(
  parameter int unsigned MAX_DIGITS = itda_pkg::MaxDigits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  itda_pkg::item_t            q_item_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [itda_pkg::CharW-1:0] char_code_o,
  output logic                       last_char_o
);

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);
  localparam int unsigned VW = itda_pkg::ValueW;

  typedef enum logic [1:0] {StIdle, StConv, StEmit} state_e;

  state_e                     state_q;
  logic [VW-1:0]              rest_q;
  logic                       neg_q;
  logic [CntW-1:0]            cnt_q;
  logic [itda_pkg::CharW-1:0] char_q;
  logic                       last_q;
  logic                       ovalid_q;
  logic [3:0]                 store_q [MAX_DIGITS];

  logic [2*VW-1:0]            prod;
  logic [VW-1:0]              quot, rem_full;
  logic [CntW-1:0]            cnt_inc, cnt_dec;
  logic                       slot_free;
  logic                       emit_char;

  assign prod      = (2*VW)'(rest_q) * (2*VW)'(itda_pkg::RecipTen);
  assign quot      = VW'(prod >> itda_pkg::RecipShift);
  assign rem_full  = rest_q - {quot[VW-4:0], 3'b000} - {quot[VW-2:0], 1'b0};
  assign cnt_inc   = cnt_q + CntW'(1);
  assign cnt_dec   = cnt_q - CntW'(1);
  assign slot_free = !ovalid_q || !stall_i;
  assign emit_char = (state_q == StEmit) && slot_free;
  assign q_pop_o   = (state_q == StIdle) && q_valid_i;

  assign valid_o     = ovalid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk_i) begin
    if (state_q == StConv) begin
      store_q[cnt_q[IdxW-1:0]] <= rem_full[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rest_q   <= '0;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
      char_q   <= '0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (emit_char) begin
        ovalid_q <= 1'b1;
      end else if (!stall_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            rest_q  <= q_item_i.mag;
            neg_q   <= q_item_i.neg;
            cnt_q   <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          rest_q <= quot;
          cnt_q  <= cnt_inc;
          if ((quot == '0) || (cnt_inc == MaxCnt)) state_q <= StEmit;
        end
        StEmit: begin
          if (slot_free) begin
            if (neg_q) begin
              char_q <= itda_pkg::AsciiMinus;
              last_q <= 1'b0;
              neg_q  <= 1'b0;
            end else begin
              char_q <= itda_pkg::AsciiZero +
                        itda_pkg::CharW'(store_q[cnt_dec[IdxW-1:0]]);
              last_q <= (cnt_dec == '0);
              cnt_q  <= cnt_dec;
              if (cnt_dec == '0) state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: rtl/itda_checker.sv
`include "int_to_decimal_ascii_macros.svh"

module itda_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               valid_i,
  input logic                               stall_o,
  input logic signed [itda_pkg::ValueW-1:0] value_i,
  input logic                               valid_o,
  input logic                               stall_i,
  input logic [itda_pkg::CharW-1:0]         char_code_o,
  input logic                               last_char_o
);

  logic is_minus, is_digit;
  assign is_minus = (char_code_o == itda_pkg::AsciiMinus);
  assign is_digit = (char_code_o >= itda_pkg::AsciiZero) &&
                    (char_code_o <= itda_pkg::AsciiZero + 8'd9);

  `ITDA_ASSERT_HOLD(a_out_hold, valid_o, stall_i, {char_code_o, last_char_o})
  `ITDA_ASSERT_HOLD(a_in_hold, valid_i, stall_o, value_i)
  `ITDA_ASSERT(a_char_set, valid_o |-> is_minus || is_digit, "bad character")
  `ITDA_ASSERT(a_minus_not_last, valid_o && is_minus |-> !last_char_o, "minus sign marked last")
  `ITDA_ASSERT(a_run_unbroken, valid_o && !stall_i && !last_char_o |=> valid_o, "gap inside a number")

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

FILE: sim/int_to_decimal_ascii_tb.sv
typedef struct packed {
  logic [itda_pkg::CharW-1:0] code;
  logic                       last;
} text_char_t;

class decimal_text_scoreboard;
  text_char_t expected_text[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // Queue the characters that one accepted value turns into.
  function void note_value(logic signed [itda_pkg::ValueW-1:0] value);
    logic                       neg;
    logic [itda_pkg::ValueW-1:0] mag;
    logic [3:0]                 digits[itda_pkg::MaxDigits];
    int                         n;
    text_char_t                 c;
    neg = value[itda_pkg::ValueW-1];
    mag = neg ? (32'd0 - value) : value;
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < itda_pkg::MaxDigits);
    if (neg) begin
      c.code = itda_pkg::AsciiMinus;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.code = itda_pkg::AsciiZero + itda_pkg::CharW'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function void check_char(logic [itda_pkg::CharW-1:0] code, logic last);
    text_char_t exp_c;
    if (expected_text.size() == 0) begin
      $display("%0t: unexpected char expected none got %0d/%0b", $time, code, last);
      errors++;
      return;
    end
    exp_c = expected_text.pop_front();
    if (exp_c.code !== code) begin
      $display("%0t: char_code expected %0d got %0d", $time, exp_c.code, code);
      errors++;
    end
    if (exp_c.last !== last) begin
      $display("%0t: last_char expected %0b got %0b", $time, exp_c.last, last);
      errors++;
    end
  endfunction
endclass

module int_to_decimal_ascii_tb;
  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               valid_i = 1'b0;
  logic                               stall_o;
  logic signed [itda_pkg::ValueW-1:0] value_i = '0;
  logic                               valid_o;
  logic                               stall_i = 1'b0;
  logic [itda_pkg::CharW-1:0]         char_code_o;
  logic                               last_char_o;

  decimal_text_scoreboard text_sb = new();
  bit  values_done = 1'b0;
  int  values_sent = 0;

  int_to_decimal_ascii dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        text_sb.note_value(value_i);
      end
      if (valid_o && !stall_i) begin
        text_sb.check_char(char_code_o, last_char_o);
      end
    end
  end

  task automatic send_value(input logic [itda_pkg::ValueW-1:0] v, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 12) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (stall_o);
    values_sent++;
  endtask

  function automatic logic [itda_pkg::ValueW-1:0] random_value();
    logic [itda_pkg::ValueW-1:0] v;
    logic [itda_pkg::ValueW-1:0] p;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p - $urandom_range(0, 1);
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  // sender
  initial begin
    logic [itda_pkg::ValueW-1:0] directed[] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
      32'hC465_3601, 32'd12345, 32'hFFFF_CFC7, 32'h5555_5555, 32'hAAAA_AAAA,
      32'd1000000, 32'd7, 32'hFFFF_FFF9, 32'd1999999999
    };
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    foreach (directed[i]) begin
      send_value(directed[i], 1'b1);
    end
    for (int i = 0; i < 80; i++) begin
      send_value(random_value(), !(i >= 30 && i < 60));
    end
    valid_i <= 1'b0;
    @(posedge clk_i);
    values_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int cyc;
    cyc = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (cyc >= 300 && cyc < 500) begin
        stall_i <= 1'b1;
      end else if (cyc >= 900 && cyc < 1300) begin
        stall_i <= 1'b0;
      end else begin
        stall_i <= ($urandom_range(0, 99) < 12);
      end
      cyc++;
      @(posedge clk_i);
    end
  end

  initial begin
    wait (values_done);
    while (text_sb.expected_text.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (text_sb.errors == 0 && text_sb.expected_text.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
